[hw/rtl/one_wire_slave_rom_emulator_core_defines.svh]
// Assertion macros shared by the ROM emulator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ONE_WIRE_SLAVE_ROM_EMULATOR_CORE_DEFINES_SVH
`define ONE_WIRE_SLAVE_ROM_EMULATOR_CORE_DEFINES_SVH

// same-cycle implication
`define OWSRE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OWSRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/owsre_pkg.sv]
// Types and constants of the 1-Wire slave ROM emulator.
// No dependencies; imported by every module of the block.
package owsre_pkg;

  localparam int TIMER_PERIOD = 32768;
  localparam int CAP_W        = $clog2(TIMER_PERIOD);
  localparam int ADDR_W       = 6;
  localparam int DATA_W       = 64;

  localparam logic [7:0] CMD_READ_ROM     = 8'h33;
  localparam logic [7:0] CMD_READ_ROM_ALT = 8'h0F;
  localparam logic [7:0] CMD_SEARCH_ROM   = 8'hF0;

  localparam logic [CAP_W-1:0] RST_LO   = CAP_W'(460);
  localparam logic [CAP_W-1:0] RST_HI   = CAP_W'(550);
  localparam logic [CAP_W-1:0] SHORT_LO = CAP_W'(1);
  localparam logic [CAP_W-1:0] SHORT_HI = CAP_W'(15);
  localparam logic [CAP_W-1:0] ONE_HI   = CAP_W'(30);
  localparam logic [CAP_W-1:0] LONG_LO  = CAP_W'(40);
  localparam logic [CAP_W-1:0] LONG_HI  = CAP_W'(120);

  localparam logic [7:0] PRESENCE_LEN_RST   = 8'd150;
  localparam logic [7:0] PRESENCE_DELAY_RST = 8'd18;
  localparam logic [7:0] ZERO_LEN_RST       = 8'd30;

  localparam logic [2:0] REG_ROM_ID         = 3'd0;
  localparam logic [2:0] REG_ENABLE         = 3'd1;
  localparam logic [2:0] REG_PRESENCE_LEN   = 3'd2;
  localparam logic [2:0] REG_PRESENCE_DELAY = 3'd3;
  localparam logic [2:0] REG_ZERO_LEN       = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_CMD    = 2'd1,
    PH_READ   = 2'd2,
    PH_SEARCH = 2'd3
  } phase_t;

  typedef struct packed {
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
  } apb_req_t;

  typedef struct packed {
    logic [63:0] rom_id;
    logic        enable;
    logic [7:0]  presence_len;
    logic [7:0]  presence_delay;
    logic [7:0]  zero_len;
  } cfg_t;

  typedef struct packed {
    logic       is_presence;
    logic [7:0] lead_us;
    logic [7:0] len_us;
  } pulse_t;

endpackage

[hw/rtl/owsre_cfg_regs.sv]
// APB register file of the ROM emulator: id, enable and pulse timing.
// Depends on owsre_pkg.
module owsre_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  owsre_pkg::apb_req_t       req,
  output logic [owsre_pkg::DATA_W-1:0] prdata,
  output owsre_pkg::cfg_t           cfg
);
  import owsre_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = req.psel && req.penable && req.pwrite;
  assign reg_idx = req.paddr[ADDR_W-1:3];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rom_id         <= '0;
      cfg_r.enable         <= 1'b0;
      cfg_r.presence_len   <= PRESENCE_LEN_RST;
      cfg_r.presence_delay <= PRESENCE_DELAY_RST;
      cfg_r.zero_len       <= ZERO_LEN_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ROM_ID:         cfg_r.rom_id         <= req.pwdata;
        REG_ENABLE:         cfg_r.enable         <= req.pwdata[0];
        REG_PRESENCE_LEN:   cfg_r.presence_len   <= req.pwdata[7:0];
        REG_PRESENCE_DELAY: cfg_r.presence_delay <= req.pwdata[7:0];
        REG_ZERO_LEN:       cfg_r.zero_len       <= req.pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROM_ID:         prdata = cfg_r.rom_id;
      REG_ENABLE:         prdata = {{(DATA_W-1){1'b0}}, cfg_r.enable};
      REG_PRESENCE_LEN:   prdata = {{(DATA_W-8){1'b0}}, cfg_r.presence_len};
      REG_PRESENCE_DELAY: prdata = {{(DATA_W-8){1'b0}}, cfg_r.presence_delay};
      REG_ZERO_LEN:       prdata = {{(DATA_W-8){1'b0}}, cfg_r.zero_len};
      default:            prdata = '0;
    endcase
  end

endmodule

[hw/rtl/owsre_link.sv]
// Link layer: edge width classing, command receive, Read ROM and Search ROM.
// Depends on owsre_pkg and the assertion macro header.
`include "one_wire_slave_rom_emulator_core_defines.svh"
module owsre_link #(
  parameter int ROM_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [owsre_pkg::CAP_W-1:0] cap,
  input  owsre_pkg::cfg_t             cfg,
  output logic                        res_valid,
  output owsre_pkg::pulse_t           res
);
  import owsre_pkg::*;

  localparam int IDX_W = ($clog2(ROM_BITS + 1) > 4) ? $clog2(ROM_BITS + 1) : 4;
  localparam int RIW   = (ROM_BITS > 1) ? $clog2(ROM_BITS) : 1;
  localparam logic [IDX_W-1:0] ROM_LIM = IDX_W'(ROM_BITS);
  localparam logic [IDX_W-1:0] CMD_LIM = IDX_W'(8);

  logic [CAP_W-1:0] last_r, last_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]       part_r, part_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  phase_t           phase_r, phase_nxt;
  logic             par_r, par_nxt;

  logic [CAP_W-1:0]    width;
  logic                is_rst, is_short, is_one, is_long;
  logic                rbit;
  logic [ROM_BITS-1:0] rom_vec;
  logic                live;

  assign live     = fire && cfg.enable;
  assign width    = cap - last_r;
  assign is_rst   = (width > RST_LO) && (width < RST_HI);
  assign is_short = (width > SHORT_LO) && (width < SHORT_HI);
  assign is_one   = (width > SHORT_LO) && (width < ONE_HI);
  assign is_long  = (width > LONG_LO) && (width < LONG_HI);
  assign rom_vec  = cfg.rom_id[ROM_BITS-1:0];
  assign rbit     = rom_vec[idx_r[RIW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      idx_r   <= '0;
      part_r  <= '0;
      cmd_r   <= '0;
      phase_r <= PH_CMD;
      par_r   <= 1'b0;
    end else begin
      last_r  <= last_nxt;
      idx_r   <= idx_nxt;
      part_r  <= part_nxt;
      cmd_r   <= cmd_nxt;
      phase_r <= phase_nxt;
      par_r   <= par_nxt;
    end
  end

  always_comb begin
    last_nxt  = last_r;
    idx_nxt   = idx_r;
    part_nxt  = part_r;
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    par_nxt   = par_r;
    res_valid = 1'b0;
    res       = '{is_presence: 1'b0, lead_us: 8'd0, len_us: cfg.zero_len};
    if (live) begin
      last_nxt = cap;
      if (is_rst) begin
        idx_nxt   = '0;
        part_nxt  = '0;
        cmd_nxt   = '0;
        phase_nxt = PH_CMD;
        par_nxt   = 1'b0;
        res_valid = 1'b1;
        res       = '{is_presence: 1'b1, lead_us: cfg.presence_delay,
                      len_us: cfg.presence_len};
      end
      par_nxt = ~par_nxt;
      if (par_nxt) begin
        unique case (phase_nxt)
          PH_READ: begin
            if ((idx_nxt < ROM_LIM) && is_short) begin
              res_valid = !rbit;
              idx_nxt   = idx_nxt + IDX_W'(1);
            end
          end
          PH_SEARCH: begin
            if (idx_nxt < ROM_LIM) begin
              if (part_nxt == 2'd2) begin
                if (is_short || is_long) begin
                  if ((is_short && !rbit) || (!is_short && rbit)) begin
                    phase_nxt = PH_IDLE;
                  end
                  part_nxt = 2'd0;
                  idx_nxt  = idx_nxt + IDX_W'(1);
                end
              end else if (is_short) begin
                res_valid = ((part_nxt == 2'd0) && !rbit) || ((part_nxt == 2'd1) && rbit);
                part_nxt  = part_nxt + 2'd1;
              end
            end
          end
          PH_CMD: begin
            if (idx_nxt < CMD_LIM) begin
              if (is_one) begin
                cmd_nxt[idx_nxt[2:0]] = 1'b1;
                idx_nxt = idx_nxt + IDX_W'(1);
              end else if (is_long) begin
                idx_nxt = idx_nxt + IDX_W'(1);
              end
            end
            if (idx_nxt == CMD_LIM) begin
              if ((cmd_nxt == CMD_READ_ROM) || (cmd_nxt == CMD_READ_ROM_ALT)) begin
                phase_nxt = PH_READ;
                idx_nxt   = '0;
                part_nxt  = '0;
              end else if (cmd_nxt == CMD_SEARCH_ROM) begin
                phase_nxt = PH_SEARCH;
                idx_nxt   = '0;
                part_nxt  = '0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  `OWSRE_ASSERT_NEXT(a_idle_sticky, clk, rst_n, (phase_r == PH_IDLE) && !(live && is_rst),
                     phase_r == PH_IDLE, "idle left without bus reset")
  `OWSRE_ASSERT_IMPL(a_part_range, clk, rst_n, 1'b1, part_r != 2'd3,
                     "search triplet position out of range")
  `OWSRE_ASSERT_IMPL(a_slot_range, clk, rst_n, (phase_r == PH_READ) || (phase_r == PH_SEARCH),
                     idx_r <= ROM_LIM, "slot index past ROM length")
  `OWSRE_ASSERT_NEXT(a_disabled_hold, clk, rst_n, !live, $stable(last_r) && $stable(par_r),
                     "state moved without an enabled capture")

endmodule

[hw/rtl/one_wire_slave_rom_emulator_core.sv]
// 1-Wire slave ROM emulator, top level: input register, link logic, result register.
// A capture waits in the input register, then any pulse word it yields is registered.
// Throughput: one capture per cycle while out_stall is low; link logic is combinational.
// Reset: synchronous, active low; clears valids and link state, loads register defaults.
// Depends on owsre_pkg, owsre_cfg_regs, owsre_link and the assertion macro header.
`include "one_wire_slave_rom_emulator_core_defines.svh"
module one_wire_slave_rom_emulator_core #(
  parameter int ROM_BITS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [owsre_pkg::CAP_W-1:0]  in_capture_time,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_pulse_is_presence,
  output logic [7:0]                   out_pulse_delay_us,
  output logic [7:0]                   out_pulse_len_us,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [owsre_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [owsre_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [owsre_pkg::DATA_W-1:0] cfg_prdata,
  output logic                         cfg_pready
);
  import owsre_pkg::*;

  apb_req_t         apb_req;
  cfg_t             cfg;
  logic             s1_valid_r, s1_valid_nxt;
  logic [CAP_W-1:0] s1_cap_r;
  logic             out_valid_r, out_valid_nxt;
  pulse_t           out_word_r;
  logic             adv, in_take, res_valid;
  pulse_t           res;

  assign apb_req    = '{psel: cfg_psel, penable: cfg_penable, pwrite: cfg_pwrite,
                        paddr: cfg_paddr, pwdata: cfg_pwdata};
  assign cfg_pready = 1'b1;

  owsre_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (apb_req),
    .prdata (cfg_prdata),
    .cfg    (cfg)
  );

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  owsre_link #(.ROM_BITS(ROM_BITS)) u_link (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (adv),
    .cap       (s1_cap_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = res_valid;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cap_r <= in_capture_time;
    end
    if (adv && res_valid) begin
      out_word_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_pulse_is_presence = out_word_r.is_presence;
  assign out_pulse_delay_us    = out_word_r.lead_us;
  assign out_pulse_len_us      = out_word_r.len_us;

  `OWSRE_ASSERT_IMPL(a_zero_no_delay, clk, rst_n, out_valid_r && !out_word_r.is_presence,
                     out_word_r.lead_us == 8'd0, "data zero pulse with nonzero delay")
  `OWSRE_ASSERT_IMPL(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_r && out_valid_r,
                     "input stalled with room downstream")
  `OWSRE_ASSERT_NEXT(a_s1_held, clk, rst_n, s1_valid_r && !adv,
                     s1_valid_r && $stable(s1_cap_r), "pending capture lost")

endmodule
